// ===== hdl/i2d_pkg.sv =====
`timescale 1ns / 1ps

package i2d_pkg;

  // Width of the converted number; bits of the input value above it are ignored.
  localparam int VALUE_WIDTH = 64;

  // Decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10(2)).
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;

  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int POS_W       = $clog2(NUM_DIGITS);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic [4:0] text_length;
    logic       last;
  } out_item_t;

  // What every digit cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,  // add-3 adjust, then shift one binary bit in from below
    CELL_SHIFT    // take the digit of the cell below
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     bin_bit;  // next binary bit, MSB first, into the lowest cell
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_SIGN,
    ST_EMIT
  } state_e;

endpackage

// ===== hdl/int64_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// Sequence: one double-dabble step per input bit, then a sizing and a sign state;
//   a minus sign, if any, is registered before the digits, which leave top cell first.
// Items: one at a time; a new item is taken only in idle, after the whole chain has
//   been unloaded. Output stalls hold the unload. The chain converts and unloads.
// Reset: rst_ni is asynchronous, active low; clears the sequencer and output valid.
module int64_to_decimal_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2d_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2d_pkg::out_item_t out_item_o
);

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  i2d_pkg::state_e state_q, state_d;

  logic [i2d_pkg::VALUE_WIDTH-1:0] mag_q, mag_d;    // magnitude, shifted out MSB first
  logic [i2d_pkg::STEP_W-1:0]      step_q, step_d;  // dabble step
  logic [i2d_pkg::POS_W-1:0]       pos_q, pos_d;    // unload position, top cell first
  logic [i2d_pkg::POS_W-1:0]       skip_q, skip_d;  // leading zero cells to drop
  logic [i2d_pkg::DIG_CNT_W-1:0]   ndig_q, ndig_d;
  logic [4:0]                      len_q, len_d;
  logic                            neg_q, neg_d;

  logic                            out_valid_q, out_valid_d;
  i2d_pkg::out_item_t              out_item_q, out_item_d;

  i2d_pkg::chain_ctrl_t            chain_ctrl;
  logic [3:0]                      top_digit;
  logic [i2d_pkg::DIG_CNT_W-1:0]   num_digits;

  logic in_take;
  logic slot_free;   // output register can take a character this cycle
  logic in_num;      // top cell holds a significant digit
  logic out_load;
  logic emit_go;     // chain advances one digit during unload
  logic last_pos;

  logic [i2d_pkg::VALUE_WIDTH-1:0] in_val;
  logic                            in_neg;

  assign in_stall_o = (state_q != i2d_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_num     = (pos_q >= skip_q);
  assign last_pos   = (pos_q == i2d_pkg::POS_W'(i2d_pkg::NUM_DIGITS - 1));

  // Only the low VALUE_WIDTH bits count; negative signed values go by magnitude.
  assign in_val = in_item_i.value[i2d_pkg::VALUE_WIDTH-1:0];
  assign in_neg = in_item_i.is_signed && in_val[i2d_pkg::VALUE_WIDTH-1];

  i2d_chain u_chain (
    .clk_i        (clk_i),
    .ctrl_i       (chain_ctrl),
    .top_digit_o  (top_digit),
    .num_digits_o (num_digits)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2d_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = i2d_pkg::ST_CONV;
        end
      end
      i2d_pkg::ST_CONV: begin
        if (step_q == i2d_pkg::STEP_W'(i2d_pkg::VALUE_WIDTH - 1)) begin
          state_d = i2d_pkg::ST_SIZE;
        end
      end
      i2d_pkg::ST_SIZE: state_d = i2d_pkg::ST_SIGN;
      i2d_pkg::ST_SIGN: begin
        if (!neg_q || slot_free) begin
          state_d = i2d_pkg::ST_EMIT;
        end
      end
      i2d_pkg::ST_EMIT: begin
        if (emit_go && last_pos) begin
          state_d = i2d_pkg::ST_IDLE;
        end
      end
      default: state_d = i2d_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: chain control, output load, counters
  // ---------------------------------------------------------------------------
  always_comb begin
    chain_ctrl.op      = i2d_pkg::CELL_HOLD;
    chain_ctrl.bin_bit = mag_q[i2d_pkg::VALUE_WIDTH-1];
    out_load           = 1'b0;
    emit_go            = 1'b0;
    out_item_d         = out_item_q;
    mag_d              = mag_q;
    step_d             = step_q;
    pos_d              = pos_q;
    skip_d             = skip_q;
    ndig_d             = ndig_q;
    len_d              = len_q;
    neg_d              = neg_q;

    unique case (state_q)
      i2d_pkg::ST_IDLE: begin
        if (in_take) begin
          chain_ctrl.op = i2d_pkg::CELL_CLEAR;
          mag_d         = in_neg ? (~in_val + i2d_pkg::VALUE_WIDTH'(1)) : in_val;
          neg_d         = in_neg;
          step_d        = '0;
        end
      end
      i2d_pkg::ST_CONV: begin
        chain_ctrl.op = i2d_pkg::CELL_DABBLE;
        mag_d         = mag_q << 1;
        step_d        = step_q + i2d_pkg::STEP_W'(1);
      end
      i2d_pkg::ST_SIZE: begin
        ndig_d = num_digits;
        skip_d = i2d_pkg::POS_W'(i2d_pkg::DIG_CNT_W'(i2d_pkg::NUM_DIGITS) - num_digits);
        len_d  = 5'(num_digits) + 5'(neg_q);
        pos_d  = '0;
      end
      i2d_pkg::ST_SIGN: begin
        if (neg_q && slot_free) begin
          out_load               = 1'b1;
          out_item_d.character   = i2d_pkg::ASCII_MINUS;
          out_item_d.text_length = len_q;
          out_item_d.last        = 1'b0;  // a digit always follows the sign
        end
      end
      i2d_pkg::ST_EMIT: begin
        // Leading zero cells shift out freely; significant ones wait for a slot.
        emit_go = !in_num || slot_free;
        if (emit_go) begin
          chain_ctrl.op = i2d_pkg::CELL_SHIFT;
          pos_d         = pos_q + i2d_pkg::POS_W'(1);
          if (in_num) begin
            out_load               = 1'b1;
            out_item_d.character   = i2d_pkg::ASCII_ZERO + {4'd0, top_digit};
            out_item_d.text_length = len_q;
            out_item_d.last        = last_pos;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2d_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    step_q     <= step_d;
    pos_q      <= pos_d;
    skip_q     <= skip_d;
    ndig_q     <= ndig_d;
    len_q      <= len_d;
    neg_q      <= neg_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Unload ends only after the whole chain has gone past the top.
  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == i2d_pkg::ST_EMIT && state_d == i2d_pkg::ST_IDLE) |-> last_pos)
    else $error("unload left before the last cell");

  // Sizing yields between one and NUM_DIGITS digits.
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == i2d_pkg::ST_SIGN) |->
      (ndig_q != '0 && ndig_q <= i2d_pkg::DIG_CNT_W'(i2d_pkg::NUM_DIGITS)))
    else $error("digit count out of range");

  // Every emitted digit is a valid BCD digit.
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == i2d_pkg::ST_EMIT && out_load) |-> (top_digit <= 4'd9))
    else $error("non-BCD digit in chain");

  // The leading digit of a multi-digit number is never zero.
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == i2d_pkg::ST_EMIT && out_load && pos_q == skip_q &&
     ndig_q != i2d_pkg::DIG_CNT_W'(1)) |-> (top_digit != 4'd0))
    else $error("leading zero emitted");

endmodule

// ===== hdl/i2d_cell.sv =====
`timescale 1ns / 1ps

// One BCD digit of the double-dabble chain.
module i2d_cell (
  input  logic             clk_i,
  input  i2d_pkg::cell_op_e op_i,
  input  logic             bit_i,
  input  logic [3:0]       digit_i,
  output logic             bit_o,
  output logic [3:0]       digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  assign adj   = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign bit_o = adj[3];

  always_comb begin
    case (op_i)
      i2d_pkg::CELL_CLEAR:  digit_d = 4'd0;
      i2d_pkg::CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      i2d_pkg::CELL_SHIFT:  digit_d = digit_i;
      default:              digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// ===== hdl/i2d_chain.sv =====
`timescale 1ns / 1ps

// Row of digit cells, least significant at index 0.
module i2d_chain (
  input  logic                           clk_i,
  input  i2d_pkg::chain_ctrl_t           ctrl_i,
  output logic [3:0]                     top_digit_o,
  output logic [i2d_pkg::DIG_CNT_W-1:0]  num_digits_o
);

  logic [3:0] digit [i2d_pkg::NUM_DIGITS];
  logic       carry [i2d_pkg::NUM_DIGITS];

  for (genvar i = 0; i < i2d_pkg::NUM_DIGITS; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;

    if (i == 0) begin : g_low
      assign bit_in   = ctrl_i.bin_bit;
      assign digit_in = 4'd0;
    end else begin : g_up
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end

    i2d_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ctrl_i.op),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .bit_o   (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit_o = digit[i2d_pkg::NUM_DIGITS-1];

  // Significant digits: index of highest nonzero cell plus one, at least one.
  always_comb begin
    num_digits_o = i2d_pkg::DIG_CNT_W'(1);
    for (int i = 1; i < i2d_pkg::NUM_DIGITS; i++) begin
      if (digit[i] != 4'd0) begin
        num_digits_o = i2d_pkg::DIG_CNT_W'(i + 1);
      end
    end
  end

endmodule
